@@ hw/rtl/bps_pkg.sv @@
// Shared types and constants for the battery precharge sequencer.
package bps_pkg;

   localparam int unsigned TIME_W   = 48;
   localparam int unsigned RC_W     = 16;
   localparam int unsigned THRESH_W = 16;
   localparam int unsigned PTIME_W  = 32;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST   = 16'd350;
   localparam logic [THRESH_W-1:0] LAST_VALUE_FLOOR_RST = 16'd100;
   localparam logic [PTIME_W-1:0]  PRECHARGE_TIME_RST   = 32'd3000000;

   typedef enum logic [1:0] {
      PH_WAIT     = 2'd0,
      PH_CHARGING = 2'd1,
      PH_COMPLETE = 2'd2,
      PH_POWERED  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE           = 2'd0,
      EV_PRECHARGE_START = 2'd1,
      EV_PRECHARGE_DONE = 2'd2,
      EV_POWER_OFF      = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JUMP_THRESHOLD   = 2'd0,
      CSR_LAST_VALUE_FLOOR = 2'd1,
      CSR_PRECHARGE_TIME   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_us;
      logic              request_load;
      logic              precharge_param;
      logic              shutdown_param;
      logic              rc_valid;
      logic [RC_W-1:0]   rc_value;
   } req_type;

   typedef struct packed {
      phase_type phase;
      logic      precharge_relay;
      logic      bypass_relay;
      logic      bms_enable;
      logic      rc_poweroff;
      event_type event_res;
   } rsp_type;

   typedef struct packed {
      logic [THRESH_W-1:0] jump_threshold;
      logic [THRESH_W-1:0] last_value_floor;
      logic [PTIME_W-1:0]  precharge_time_us;
   } cfg_type;

   typedef struct packed {
      phase_type         phase;
      logic [TIME_W-1:0] charge_start_time;
      logic [RC_W-1:0]   last_rc_value;
      logic              precharge_request;
      logic              shutdown_request;
      logic              precharge_relay;
      logic              bypass_relay;
      logic              bms_enable;
   } state_type;

endpackage

@@ hw/rtl/bps_csr.sv @@
// Configuration registers of the battery precharge sequencer.
module bps_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bps_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [bps_pkg::CSR_W-1:0]        csr_wdata,
   output bps_pkg::cfg_type                 cfg
);
   import bps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_JUMP_THRESHOLD:   cfg_in.jump_threshold    = csr_wdata[THRESH_W-1:0];
            CSR_LAST_VALUE_FLOOR: cfg_in.last_value_floor  = csr_wdata[THRESH_W-1:0];
            CSR_PRECHARGE_TIME:   cfg_in.precharge_time_us = csr_wdata[PTIME_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.jump_threshold    <= JUMP_THRESHOLD_RST;
         cfg_ff.last_value_floor  <= LAST_VALUE_FLOOR_RST;
         cfg_ff.precharge_time_us <= PRECHARGE_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/bps_step.sv @@
// Per-tick step logic: request load, RC jump detect and phase sequencing.
module bps_step (
   input  bps_pkg::req_type   item,
   input  bps_pkg::cfg_type   cfg,
   input  bps_pkg::state_type state,
   output bps_pkg::state_type state_next,
   output bps_pkg::rsp_type   result
);
   import bps_pkg::*;

   logic [RC_W-1:0]   rc_diff;
   logic              rc_jump;
   logic [TIME_W-1:0] elapsed;
   logic              charge_done;
   state_type         mid;

   assign rc_diff = (item.rc_value > state.last_rc_value)
                    ? item.rc_value - state.last_rc_value
                    : state.last_rc_value - item.rc_value;
   assign rc_jump = item.rc_valid && (rc_diff > cfg.jump_threshold)
                    && (state.last_rc_value > cfg.last_value_floor);
   assign elapsed = item.time_us - state.charge_start_time;
   assign charge_done = elapsed >= {{(TIME_W-PTIME_W){1'b0}}, cfg.precharge_time_us};

   always_comb begin
      mid = state;
      if (item.request_load) begin
         mid.precharge_request = item.precharge_param;
         mid.shutdown_request  = item.shutdown_param;
      end
      if (rc_jump) begin
         mid.shutdown_request = 1'b1;
      end
      if (item.rc_valid) begin
         mid.last_rc_value = item.rc_value;
      end
   end

   always_comb begin
      state_next = mid;
      result.event_res = EV_NONE;
      case (mid.phase)
         PH_WAIT: begin
            if (mid.precharge_request) begin
               state_next.precharge_relay   = 1'b1;
               state_next.bms_enable        = 1'b1;
               state_next.phase             = PH_CHARGING;
               state_next.charge_start_time = item.time_us;
               result.event_res             = EV_PRECHARGE_START;
            end else begin
               state_next.precharge_relay = 1'b0;
               state_next.bypass_relay    = 1'b0;
            end
            state_next.shutdown_request = 1'b0;
         end
         PH_CHARGING: begin
            if (charge_done) begin
               state_next.bypass_relay = 1'b1;
               state_next.phase        = PH_COMPLETE;
               result.event_res        = EV_PRECHARGE_DONE;
            end
         end
         PH_COMPLETE: begin
            state_next.precharge_request = 1'b0;
            state_next.precharge_relay   = 1'b0;
            state_next.phase             = PH_POWERED;
         end
         PH_POWERED: begin
            if (mid.shutdown_request) begin
               state_next.bypass_relay = 1'b0;
               state_next.bms_enable   = 1'b0;
               state_next.phase        = PH_WAIT;
               result.event_res        = EV_POWER_OFF;
            end
            state_next.precharge_request = 1'b0;
         end
         default: begin
            state_next = mid;
         end
      endcase
      result.phase           = state_next.phase;
      result.precharge_relay = state_next.precharge_relay;
      result.bypass_relay    = state_next.bypass_relay;
      result.bms_enable      = state_next.bms_enable;
      result.rc_poweroff     = rc_jump;
   end

endmodule

@@ hw/rtl/battery_precharge_sequencer_top.sv @@
// A req item passes through the input register and then the result register before its
// result is offered on rsp_tvalid and rsp_tdata.
// Throughput: one item per cycle while rsp_tready is high; the step logic is one tick.
// A result held by rsp_tready low still lets one more item enter the input register.
// Reset: synchronous, active high; clears phase, requests, relays, last RC value,
// start time and both valid flags, and loads the configuration register defaults.
module battery_precharge_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   // time_us[47:0], request_load, precharge_param, shutdown_param, rc_valid,
   // rc_value[15:0], zero fill
   input  logic [bps_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // phase[1:0], precharge_relay, bypass_relay, bms_enable, rc_poweroff, event_res[1:0]
   output logic [bps_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [bps_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [bps_pkg::CSR_W-1:0]         csr_wdata
);
   import bps_pkg::*;

   cfg_type   cfg;
   req_type   req_item;
   req_type   in_ff;
   logic      in_vld_ff;
   logic      in_vld_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_step;
   logic      rsp_vld_ff;
   logic      rsp_vld_in;
   state_type state_ff;
   state_type state_in;
   logic      advance;
   logic      req_xfer;

   bps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bps_step u_step (
      .item       (in_ff),
      .cfg        (cfg),
      .state      (state_ff),
      .state_next (state_in),
      .result     (rsp_step)
   );

   assign req_item.time_us         = req_tdata[47:0];
   assign req_item.request_load    = req_tdata[48];
   assign req_item.precharge_param = req_tdata[49];
   assign req_item.shutdown_param  = req_tdata[50];
   assign req_item.rc_valid        = req_tdata[51];
   assign req_item.rc_value        = req_tdata[67:52];

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign in_vld_in  = req_xfer || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_step;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_ff.event_res, rsp_ff.rc_poweroff, rsp_ff.bms_enable,
                        rsp_ff.bypass_relay, rsp_ff.precharge_relay, rsp_ff.phase};

endmodule
